### sv/pl0sm_pkg.sv
`timescale 1ns / 1ps
package pl0sm_pkg;

    localparam int STACK_DEPTH = 2048;
    localparam int WORD_BITS   = 32;
    localparam int ADDR_BITS   = $clog2(STACK_DEPTH);
    localparam int PC_BITS     = 16;

    typedef logic [WORD_BITS-1:0] t_word;
    typedef logic [ADDR_BITS-1:0] t_addr;
    typedef logic [PC_BITS-1:0]   t_pc;

    // operations
    localparam logic [3:0] OP_BRK = 4'd0;
    localparam logic [3:0] OP_LIT = 4'd1;
    localparam logic [3:0] OP_OPR = 4'd2;
    localparam logic [3:0] OP_LOD = 4'd3;
    localparam logic [3:0] OP_STO = 4'd4;
    localparam logic [3:0] OP_CAL = 4'd5;
    localparam logic [3:0] OP_INC = 4'd6;
    localparam logic [3:0] OP_JMP = 4'd7;
    localparam logic [3:0] OP_JPC = 4'd8;
    localparam logic [3:0] OP_SIO = 4'd9;

    // ALU functions
    localparam logic [3:0] OPR_RET = 4'd0;
    localparam logic [3:0] OPR_NEG = 4'd1;
    localparam logic [3:0] OPR_ADD = 4'd2;
    localparam logic [3:0] OPR_SUB = 4'd3;
    localparam logic [3:0] OPR_MUL = 4'd4;
    localparam logic [3:0] OPR_DIV = 4'd5;
    localparam logic [3:0] OPR_ODD = 4'd6;
    localparam logic [3:0] OPR_MOD = 4'd7;
    localparam logic [3:0] OPR_EQL = 4'd8;
    localparam logic [3:0] OPR_NEQ = 4'd9;
    localparam logic [3:0] OPR_LSS = 4'd10;
    localparam logic [3:0] OPR_LEQ = 4'd11;
    localparam logic [3:0] OPR_GTR = 4'd12;
    localparam logic [3:0] OPR_GEQ = 4'd13;
    localparam int         OPR_COUNT = 14;

    // I/O codes
    localparam t_word SIO_WRITE = t_word'(1);
    localparam t_word SIO_READ  = t_word'(2);
    localparam t_word SIO_HALT  = t_word'(3);

    // run status
    localparam logic [1:0] RUN_CONT  = 2'd0;
    localparam logic [1:0] RUN_HALT  = 2'd1;
    localparam logic [1:0] RUN_PAUSE = 2'd2;
    localparam logic [1:0] RUN_ERROR = 2'd3;

    // error causes
    localparam logic [2:0] ERR_NONE    = 3'd0;
    localparam logic [2:0] ERR_STACK   = 3'd1;
    localparam logic [2:0] ERR_PC      = 3'd2;
    localparam logic [2:0] ERR_DIVZERO = 3'd3;
    localparam logic [2:0] ERR_OVFL    = 3'd4;
    localparam logic [2:0] ERR_ILLEGAL = 3'd5;
    localparam logic [2:0] ERR_UNKNOWN = 3'd6;

    function automatic logic idx_bad(input t_word x);
        return x >= t_word'(STACK_DEPTH);
    endfunction

endpackage

### sv/pl0sm_in_if.sv
`timescale 1ns / 1ps
interface pl0sm_in_if;
    logic               valid;
    logic               ready;
    logic [3:0]         operation;
    logic [3:0]         level;
    logic signed [31:0] immediate;
    logic signed [31:0] read_value;

    modport source(output valid, output operation, output level, output immediate,
                   output read_value, input ready);
    modport sink(input valid, input operation, input level, input immediate,
                 input read_value, output ready);
endinterface

### sv/pl0sm_out_if.sv
`timescale 1ns / 1ps
interface pl0sm_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         run_status;
    logic [2:0]         error_cause;
    logic [15:0]        next_pc;
    logic               write_valid;
    logic signed [31:0] write_value;
    logic               read_used;
    logic signed [31:0] base_out;
    logic signed [31:0] top_out;

    modport source(output valid, output run_status, output error_cause, output next_pc,
                   output write_valid, output write_value, output read_used,
                   output base_out, output top_out, input ready);
    modport sink(input valid, input run_status, input error_cause, input next_pc,
                 input write_valid, input write_value, input read_used,
                 input base_out, input top_out, output ready);
endinterface

### sv/pl0sm_ram.sv
`timescale 1ns / 1ps
module pl0sm_ram #(
    parameter int DEPTH = 2048,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### sv/pl0sm_div.sv
`timescale 1ns / 1ps
module pl0sm_div import pl0sm_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_word i_dividend,
    input  t_word i_divisor,
    output logic  o_done,
    output t_word o_quot,
    output t_word o_rem
);
    localparam int CNT_BITS = $clog2(WORD_BITS) + 1;

    logic [CNT_BITS-1:0] r_cnt;
    logic                r_busy;
    logic                r_done;
    t_word               r_q;
    t_word               r_r;
    t_word               r_d;
    logic [WORD_BITS:0]  w_trial;
    logic                w_fit;

    // shift in one dividend bit, subtract when the divisor fits
    assign w_trial = {r_r, r_q[WORD_BITS-1]};
    assign w_fit   = w_trial >= {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_BITS'(WORD_BITS);
                r_q    <= i_dividend;
                r_r    <= '0;
                r_d    <= i_divisor;
            end else if (r_busy) begin
                r_r <= w_fit ? WORD_BITS'(w_trial - {1'b0, r_d})
                             : w_trial[WORD_BITS-1:0];
                r_q <= {r_q[WORD_BITS-2:0], w_fit};
                r_cnt <= r_cnt - CNT_BITS'(1);
                if (r_cnt == CNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_r;
endmodule

### sv/pl0_stack_machine_core.sv
`timescale 1ns / 1ps
// P-machine instruction executor. Each accepted word is one instruction and yields one
// result word with status, next PC, I/O and pointers. After reset the stack RAM is
// swept to zero, one entry a cycle (all STACK_DEPTH = 2048 entries), and no instruction
// is taken until the sweep ends. Register-only work (INC, JMP, halt) goes from decode
// straight to the write-back step; each stack RAM read passes through S_RD and S_RDW
// (one port access with a registered output); a static link walk runs S_WALK, S_RD and
// S_RDW once per level walked; an execute step follows any read or walk, then one write
// step per stack word (four for CAL); DIV and MOD wait in S_DIV on a one-bit-per-cycle
// divider. A failing step stops where the fault is found and posts its result through
// S_FAIL and S_FIN; a pause or a stopped machine goes from decode straight to S_FIN. One
// instruction is in flight at a time; a finished result waits in the output register
// while the next instruction is accepted; ready rises in the same cycle as the result.
module pl0_stack_machine_core import pl0sm_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [15:0]    i_cfg_data,
    pl0sm_in_if.sink       i_cmd,
    pl0sm_out_if.source    o_res
);
    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_DEC, S_RD, S_RDW, S_WALK, S_EXEC, S_DIV, S_WR, S_FAIL, S_FIN
    } t_state;

    localparam t_word MOST_NEG = {1'b1, {(WORD_BITS-1){1'b0}}};

    t_state     r_state;
    t_addr      r_clr;
    t_pc        r_code_len;
    t_word      r_bp, r_sp, r_nbp, r_nsp;
    t_pc        r_pc, r_npc;
    logic [1:0] r_stop;
    logic [3:0] r_op, r_lvl, r_cnt;
    t_word      r_imm, r_rv;
    t_word      r_a, r_b, r_cur, r_raddr, r_waddr, r_wval;
    logic       r_step, r_walking;
    logic [2:0] r_wn, r_wk;
    logic [1:0] r_status;
    logic [2:0] r_cause;
    logic       r_wvalid, r_rused;
    t_word      r_wvalue;

    logic       r_ovalid;
    logic [1:0] r_o_status;
    logic [2:0] r_o_cause;
    t_pc        r_o_pc;
    logic       r_o_wvalid, r_o_rused;
    t_word      r_o_wvalue, r_o_bp, r_o_sp;

    logic  w_we;
    t_addr w_waddr;
    t_word w_wdata, w_rdata, w_wr_addr, w_wr_val;
    logic  w_div_start, w_div_done, w_is_div;
    t_word w_uq, w_ur, w_ua, w_ub, w_sq, w_sr;

    // stack write address and value; CAL lays down its four frame words in turn
    always_comb begin
        w_wr_addr = r_waddr;
        w_wr_val  = r_wval;
        if (r_op == OP_CAL) begin
            w_wr_addr = r_sp + t_word'(1) + t_word'(r_wk);
            case (r_wk)
                3'd0:    w_wr_val = '0;
                3'd1:    w_wr_val = r_b;
                3'd2:    w_wr_val = r_bp;
                default: w_wr_val = t_word'(r_pc + t_pc'(1));
            endcase
        end
    end

    assign w_we    = (r_state == S_CLR) || (r_state == S_WR && r_wk < r_wn);
    assign w_waddr = (r_state == S_CLR) ? r_clr : w_wr_addr[ADDR_BITS-1:0];
    assign w_wdata = (r_state == S_CLR) ? '0 : w_wr_val;

    pl0sm_ram #(.DEPTH(STACK_DEPTH), .WIDTH(WORD_BITS)) u_stack (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_raddr[ADDR_BITS-1:0]),
        .o_rdata (w_rdata)
    );

    assign w_is_div    = (r_op == OP_OPR) &&
                         (r_imm[3:0] == OPR_DIV || r_imm[3:0] == OPR_MOD);
    assign w_div_start = (r_state == S_EXEC) && w_is_div && (r_b != '0) &&
                         !(r_a == MOST_NEG && r_b == '1);
    assign w_ua = r_a[WORD_BITS-1] ? -r_a : r_a;
    assign w_ub = r_b[WORD_BITS-1] ? -r_b : r_b;

    pl0sm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_ua),
        .i_divisor  (w_ub),
        .o_done     (w_div_done),
        .o_quot     (w_uq),
        .o_rem      (w_ur)
    );

    assign w_sq = (r_a[WORD_BITS-1] ^ r_b[WORD_BITS-1]) ? -w_uq : w_uq;
    assign w_sr = r_a[WORD_BITS-1] ? -w_ur : w_ur;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_clr      <= '0;
            r_code_len <= '0;
            r_bp       <= t_word'(1);
            r_sp       <= '0;
            r_pc       <= '0;
            r_stop     <= RUN_CONT;
            r_ovalid   <= 1'b0;
            r_wn       <= '0;
            r_wk       <= '0;
            r_walking  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_code_len <= i_cfg_data;
            end
            if (o_res.ready && r_state != S_FIN) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + t_addr'(1);
                    if (r_clr == t_addr'(STACK_DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_cmd.valid) begin
                        r_op    <= i_cmd.operation;
                        r_lvl   <= i_cmd.level;
                        r_imm   <= t_word'(i_cmd.immediate);
                        r_rv    <= t_word'(i_cmd.read_value);
                        r_state <= S_DEC;
                    end
                end
                S_DEC: begin
                    r_nbp     <= r_bp;
                    r_nsp     <= r_sp;
                    r_npc     <= r_pc + t_pc'(1);
                    r_status  <= RUN_CONT;
                    r_cause   <= ERR_NONE;
                    r_wvalid  <= 1'b0;
                    r_wvalue  <= '0;
                    r_rused   <= 1'b0;
                    r_wn      <= '0;
                    r_wk      <= '0;
                    r_walking <= 1'b0;
                    r_step    <= 1'b0;
                    r_cur     <= r_bp;
                    r_cnt     <= r_lvl;
                    if (r_stop == RUN_HALT || r_stop == RUN_ERROR) begin
                        r_status <= r_stop;
                        r_state  <= S_FIN;
                    end else if (r_pc >= r_code_len) begin
                        r_cause <= ERR_PC;
                        r_state <= S_FAIL;
                    end else begin
                        case (r_op)
                            OP_BRK: begin
                                if (r_lvl != '0) begin
                                    r_status <= RUN_PAUSE;
                                    r_stop   <= RUN_PAUSE;
                                    r_state  <= S_FIN;
                                end else begin
                                    r_cause <= ERR_ILLEGAL;
                                    r_state <= S_FAIL;
                                end
                            end
                            OP_LIT, OP_SIO: begin
                                if (r_op == OP_SIO && r_imm == SIO_HALT) begin
                                    r_nbp    <= '0;
                                    r_nsp    <= '0;
                                    r_npc    <= '0;
                                    r_status <= RUN_HALT;
                                    r_state  <= S_WR;
                                end else if (r_op == OP_SIO && r_imm == SIO_WRITE) begin
                                    r_nsp   <= r_sp - t_word'(1);
                                    r_raddr <= r_sp;
                                    r_state <= S_RD;
                                end else if (r_op == OP_SIO && r_imm != SIO_READ) begin
                                    r_cause <= ERR_UNKNOWN;
                                    r_state <= S_FAIL;
                                end else if (idx_bad(r_sp + t_word'(1))) begin
                                    r_cause <= ERR_STACK;
                                    r_state <= S_FAIL;
                                end else begin
                                    r_nsp   <= r_sp + t_word'(1);
                                    r_waddr <= r_sp + t_word'(1);
                                    r_wval  <= (r_op == OP_SIO) ? r_rv : r_imm;
                                    r_rused <= (r_op == OP_SIO);
                                    r_wn    <= 3'd1;
                                    r_state <= S_WR;
                                end
                            end
                            OP_OPR: begin
                                if (r_imm >= t_word'(OPR_COUNT)) begin
                                    r_cause <= ERR_UNKNOWN;
                                    r_state <= S_FAIL;
                                end else begin
                                    r_state <= S_RD;
                                    case (r_imm[3:0])
                                        OPR_RET: begin
                                            r_nsp   <= r_bp - t_word'(1);
                                            r_raddr <= r_bp + t_word'(3);
                                        end
                                        OPR_NEG, OPR_ODD: begin
                                            r_raddr <= r_sp;
                                        end
                                        default: begin
                                            r_nsp   <= r_sp - t_word'(1);
                                            r_raddr <= r_sp - t_word'(1);
                                        end
                                    endcase
                                end
                            end
                            OP_LOD: begin
                                r_state <= S_WALK;
                            end
                            OP_STO, OP_JPC: begin
                                r_nsp   <= r_sp - t_word'(1);
                                r_raddr <= r_sp;
                                r_state <= S_RD;
                            end
                            OP_CAL: begin
                                if (idx_bad(r_sp + t_word'(1))) begin
                                    r_cause <= ERR_STACK;
                                    r_state <= S_FAIL;
                                end else begin
                                    r_state <= S_WALK;
                                end
                            end
                            OP_INC: begin
                                r_nsp   <= r_sp + r_imm;
                                r_state <= S_WR;
                            end
                            OP_JMP: begin
                                r_npc   <= r_imm[PC_BITS-1:0];
                                r_state <= S_WR;
                            end
                            default: begin
                                r_cause <= ERR_UNKNOWN;
                                r_state <= S_FAIL;
                            end
                        endcase
                    end
                end
                S_RD: begin
                    if (idx_bad(r_raddr)) begin
                        r_cause <= ERR_STACK;
                        r_state <= S_FAIL;
                    end else if (r_walking && r_op == OP_CAL &&
                                 r_raddr == r_sp + t_word'(1)) begin
                        // link word is the frame's own first slot, still pending as zero
                        r_cur   <= '0;
                        r_cnt   <= r_cnt - 4'd1;
                        r_state <= S_WALK;
                    end else begin
                        r_state <= S_RDW;
                    end
                end
                S_RDW: begin
                    if (r_walking) begin
                        r_cur   <= w_rdata;
                        r_cnt   <= r_cnt - 4'd1;
                        r_state <= S_WALK;
                    end else if (r_op == OP_STO) begin
                        r_a     <= w_rdata;
                        r_state <= S_WALK;
                    end else if (r_op == OP_OPR && r_imm[3:0] != OPR_NEG &&
                                 r_imm[3:0] != OPR_ODD && !r_step) begin
                        r_a     <= w_rdata;
                        r_step  <= 1'b1;
                        r_raddr <= (r_imm[3:0] == OPR_RET) ? r_bp + t_word'(2) : r_sp;
                        r_state <= S_RD;
                    end else begin
                        if (r_step) begin
                            r_b <= w_rdata;
                        end else begin
                            r_a <= w_rdata;
                        end
                        r_state <= S_EXEC;
                    end
                end
                S_WALK: begin
                    if (r_cnt == '0) begin
                        r_walking <= 1'b0;
                        r_b       <= r_cur;
                        if (r_op == OP_LOD) begin
                            r_raddr <= r_cur + r_imm;
                            r_state <= S_RD;
                        end else begin
                            r_state <= S_EXEC;
                        end
                    end else begin
                        r_walking <= 1'b1;
                        r_raddr   <= r_cur + t_word'(1);
                        r_state   <= S_RD;
                    end
                end
                S_EXEC: begin
                    r_state <= S_WR;
                    r_waddr <= r_nsp;
                    case (r_op)
                        OP_OPR: begin
                            r_wn <= 3'd1;
                            case (r_imm[3:0])
                                OPR_RET: begin
                                    r_wn  <= '0;
                                    r_nbp <= r_b;
                                    r_npc <= r_a[PC_BITS-1:0];
                                end
                                OPR_NEG: r_wval <= -r_a;
                                OPR_ODD: r_wval <= t_word'(r_a[0]);
                                OPR_ADD: r_wval <= r_a + r_b;
                                OPR_SUB: r_wval <= r_a - r_b;
                                OPR_MUL: r_wval <= r_a * r_b;
                                OPR_EQL: r_wval <= t_word'(r_a == r_b);
                                OPR_NEQ: r_wval <= t_word'(r_a != r_b);
                                OPR_LSS: r_wval <= t_word'($signed(r_a) < $signed(r_b));
                                OPR_LEQ: r_wval <= t_word'($signed(r_a) <= $signed(r_b));
                                OPR_GTR: r_wval <= t_word'($signed(r_a) > $signed(r_b));
                                OPR_GEQ: r_wval <= t_word'($signed(r_a) >= $signed(r_b));
                                default: begin
                                    if (r_b == '0) begin
                                        r_cause <= ERR_DIVZERO;
                                        r_state <= S_FAIL;
                                    end else if (r_a == MOST_NEG && r_b == '1) begin
                                        r_cause <= ERR_OVFL;
                                        r_state <= S_FAIL;
                                    end else begin
                                        r_state <= S_DIV;
                                    end
                                end
                            endcase
                        end
                        OP_LOD: begin
                            if (idx_bad(r_sp + t_word'(1))) begin
                                r_cause <= ERR_STACK;
                                r_state <= S_FAIL;
                            end else begin
                                r_nsp   <= r_sp + t_word'(1);
                                r_waddr <= r_sp + t_word'(1);
                                r_wval  <= r_a;
                                r_wn    <= 3'd1;
                            end
                        end
                        OP_STO: begin
                            if (idx_bad(r_b + r_imm)) begin
                                r_cause <= ERR_STACK;
                                r_state <= S_FAIL;
                            end else begin
                                r_waddr <= r_b + r_imm;
                                r_wval  <= r_a;
                                r_wn    <= 3'd1;
                            end
                        end
                        OP_CAL: begin
                            if (idx_bad(r_sp + t_word'(2)) || idx_bad(r_sp + t_word'(3)) ||
                                idx_bad(r_sp + t_word'(4))) begin
                                r_cause <= ERR_STACK;
                                r_state <= S_FAIL;
                            end else begin
                                r_wn  <= 3'd4;
                                r_nbp <= r_sp + t_word'(1);
                                r_npc <= r_imm[PC_BITS-1:0];
                            end
                        end
                        OP_JPC: begin
                            if (r_a == '0) begin
                                r_npc <= r_imm[PC_BITS-1:0];
                            end
                        end
                        default: begin
                            r_wvalid <= 1'b1;
                            r_wvalue <= r_a;
                        end
                    endcase
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_wval  <= (r_imm[3:0] == OPR_DIV) ? w_sq : w_sr;
                        r_wn    <= 3'd1;
                        r_state <= S_WR;
                    end
                end
                S_WR: begin
                    if (r_wk < r_wn) begin
                        r_wk <= r_wk + 3'd1;
                    end else begin
                        r_bp    <= r_nbp;
                        r_sp    <= r_nsp;
                        r_pc    <= r_npc;
                        r_stop  <= r_status;
                        r_state <= S_FIN;
                    end
                end
                S_FAIL: begin
                    // drop all effects, hold PC
                    r_status <= RUN_ERROR;
                    r_stop   <= RUN_ERROR;
                    r_wvalid <= 1'b0;
                    r_wvalue <= '0;
                    r_rused  <= 1'b0;
                    r_state  <= S_FIN;
                end
                S_FIN: begin
                    if (!r_ovalid || o_res.ready) begin
                        r_ovalid   <= 1'b1;
                        r_o_status <= r_status;
                        r_o_cause  <= r_cause;
                        r_o_pc     <= r_pc;
                        r_o_wvalid <= r_wvalid;
                        r_o_wvalue <= r_wvalue;
                        r_o_rused  <= r_rused;
                        r_o_bp     <= r_bp;
                        r_o_sp     <= r_sp;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_cmd.ready       = (r_state == S_IDLE);
    assign o_res.valid       = r_ovalid;
    assign o_res.run_status  = r_o_status;
    assign o_res.error_cause = r_o_cause;
    assign o_res.next_pc     = r_o_pc;
    assign o_res.write_valid = r_o_wvalid;
    assign o_res.write_value = r_o_wvalue;
    assign o_res.read_used   = r_o_rused;
    assign o_res.base_out    = r_o_bp;
    assign o_res.top_out     = r_o_sp;
endmodule
